FILE: sv/segment_quad_edge_intersect_assert.svh
// assertion macros for the segment to quadrilateral edge intersection block
`ifndef SEGMENT_QUAD_EDGE_INTERSECT_ASSERT_SVH
`define SEGMENT_QUAD_EDGE_INTERSECT_ASSERT_SVH
`ifndef ASSERT_OFF
`define SEQI_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("seqi check failed");
`define SEQI_ASSERT_NEXT(lbl, clk, rst, pre, post) \
  `SEQI_ASSERT(lbl, clk, rst, (pre) |=> (post))
`else
`define SEQI_ASSERT(lbl, clk, rst, prop)
`define SEQI_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif
`endif

FILE: sv/seqi_pkg.sv
// shared constants and types for the segment to quadrilateral edge intersection block
package seqi_pkg;

  localparam int CW         = 24;
  localparam int BW         = CW + 1;
  localparam int NW         = 2 * BW + 1;
  localparam int RW         = NW + 1;
  localparam int FRAC_W     = 17;
  localparam int FRAC_ONE   = 65536;
  localparam int IDX_W      = 2;
  localparam int LANES      = 4;
  localparam int NORM_W     = 16;
  localparam int Q14_SH     = 14;
  localparam int ONE_Q14    = 16384;
  localparam int QN_W       = Q14_SH + 1;
  localparam int LEN_W      = CW + 1;
  localparam int SQ_W       = 2 * LEN_W;
  localparam int REM_W      = LEN_W + 3;
  localparam int DR_W       = CW + Q14_SH + 2;
  localparam int LANE_LAT   = 3 + FRAC_W;
  localparam int NORM_LAT   = 3 + LEN_W + 1 + QN_W + 1;
  localparam int PIPE_LAT   = LANE_LAT + 1 + NORM_LAT;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [BW-1:0] edge_t;

  typedef struct packed {
    logic              cand;
    logic [FRAC_W-1:0] frac;
    edge_t             bx;
    edge_t             by;
  } lane_res_t;

  typedef struct packed {
    logic              hit;
    logic [FRAC_W-1:0] frac;
    logic [IDX_W-1:0]  idx;
  } tag_t;

  typedef struct packed {
    tag_t  tag;
    edge_t bx;
    edge_t by;
  } pick_t;

  typedef struct packed {
    tag_t                     tag;
    logic signed [NORM_W-1:0] nx;
    logic signed [NORM_W-1:0] ny;
  } res_t;

endpackage

FILE: sv/seqi_in_if.sv
// input channel: segment and quadrilateral corners
interface seqi_in_if;
  logic            valid;
  logic            ready;
  seqi_pkg::coord_t start_x;
  seqi_pkg::coord_t start_y;
  seqi_pkg::coord_t path_x;
  seqi_pkg::coord_t path_y;
  seqi_pkg::coord_t corner0_x;
  seqi_pkg::coord_t corner0_y;
  seqi_pkg::coord_t corner1_x;
  seqi_pkg::coord_t corner1_y;
  seqi_pkg::coord_t corner2_x;
  seqi_pkg::coord_t corner2_y;
  seqi_pkg::coord_t corner3_x;
  seqi_pkg::coord_t corner3_y;

  modport source (
    output valid, start_x, start_y, path_x, path_y, corner0_x, corner0_y, corner1_x,
           corner1_y, corner2_x, corner2_y, corner3_x, corner3_y,
    input  ready
  );
  modport sink (
    input  valid, start_x, start_y, path_x, path_y, corner0_x, corner0_y, corner1_x,
           corner1_y, corner2_x, corner2_y, corner3_x, corner3_y,
    output ready
  );
endinterface

FILE: sv/seqi_out_if.sv
// output channel: hit result
interface seqi_out_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   hit;
  logic [seqi_pkg::FRAC_W-1:0]            hit_fraction;
  logic [seqi_pkg::IDX_W-1:0]             edge_index;
  logic signed [seqi_pkg::NORM_W-1:0]     normal_x;
  logic signed [seqi_pkg::NORM_W-1:0]     normal_y;

  modport source (
    output valid, hit, hit_fraction, edge_index, normal_x, normal_y,
    input  ready
  );
  modport sink (
    input  valid, hit, hit_fraction, edge_index, normal_x, normal_y,
    output ready
  );
endinterface

FILE: sv/seqi_lane.sv
// one edge lane: facing and range tests, then bit-per-stage path fraction divider
module seqi_lane (
  input  logic                clk,
  input  logic                en,
  input  seqi_pkg::coord_t    start_x,
  input  seqi_pkg::coord_t    start_y,
  input  seqi_pkg::coord_t    path_x,
  input  seqi_pkg::coord_t    path_y,
  input  seqi_pkg::coord_t    ca_x,
  input  seqi_pkg::coord_t    ca_y,
  input  seqi_pkg::coord_t    cb_x,
  input  seqi_pkg::coord_t    cb_y,
  output seqi_pkg::lane_res_t res
);

  localparam int BW     = seqi_pkg::BW;
  localparam int NW     = seqi_pkg::NW;
  localparam int RW     = seqi_pkg::RW;
  localparam int FRAC_W = seqi_pkg::FRAC_W;

  seqi_pkg::edge_t bx1, by1, dx1, dy1, px1, py1;
  seqi_pkg::edge_t bx2, by2, bx3, by3;
  logic signed [2*BW-1:0] m_pybx, m_pxby, m_pxdy, m_pydx, m_bxdy, m_bydx;
  logic signed [NW-1:0] delta3, tnum3, snum3;

  logic [RW-1:0]     rem_s  [FRAC_W];
  logic [RW-1:0]     den_s  [FRAC_W];
  logic [FRAC_W-1:0] q_s    [FRAC_W];
  logic              cand_s [FRAC_W];
  seqi_pkg::edge_t   bx_s   [FRAC_W];
  seqi_pkg::edge_t   by_s   [FRAC_W];

  logic          cand0, ge0;
  logic [RW-1:0] num0, den0;

  always_ff @(posedge clk) begin
    if (en) begin
      bx1 <= BW'(cb_x) - BW'(ca_x);
      by1 <= BW'(cb_y) - BW'(ca_y);
      dx1 <= BW'(ca_x) - BW'(start_x);
      dy1 <= BW'(ca_y) - BW'(start_y);
      px1 <= BW'(path_x);
      py1 <= BW'(path_y);
      m_pybx <= py1 * bx1;
      m_pxby <= px1 * by1;
      m_pxdy <= px1 * dy1;
      m_pydx <= py1 * dx1;
      m_bxdy <= bx1 * dy1;
      m_bydx <= by1 * dx1;
      bx2 <= bx1;
      by2 <= by1;
      delta3 <= NW'(m_pybx) - NW'(m_pxby);
      tnum3  <= NW'(m_pxdy) - NW'(m_pydx);
      snum3  <= NW'(m_bxdy) - NW'(m_bydx);
      bx3 <= bx2;
      by3 <= by2;
    end
  end

  // integer bit of the fraction
  always_comb begin
    cand0 = (delta3 > 0) && !tnum3[NW-1] && (tnum3 <= delta3)
         && !snum3[NW-1] && (snum3 <= delta3);
    num0 = RW'($unsigned(snum3));
    den0 = RW'($unsigned(delta3));
    ge0  = num0 >= den0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_s[0]  <= ge0 ? num0 - den0 : num0;
      den_s[0]  <= den0;
      q_s[0]    <= FRAC_W'(ge0);
      cand_s[0] <= cand0;
      bx_s[0]   <= bx3;
      by_s[0]   <= by3;
    end
  end

  for (genvar k = 1; k < FRAC_W; k++) begin : g_div
    logic [RW-1:0] sh;
    logic          ge;
    always_comb begin
      sh = {rem_s[k-1][RW-2:0], 1'b0};
      ge = sh >= den_s[k-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k]  <= ge ? sh - den_s[k-1] : sh;
        den_s[k]  <= den_s[k-1];
        q_s[k]    <= {q_s[k-1][FRAC_W-2:0], ge};
        cand_s[k] <= cand_s[k-1];
        bx_s[k]   <= bx_s[k-1];
        by_s[k]   <= by_s[k-1];
      end
    end
  end

  assign res = '{cand: cand_s[FRAC_W-1], frac: q_s[FRAC_W-1],
                 bx: bx_s[FRAC_W-1], by: by_s[FRAC_W-1]};

endmodule

FILE: sv/seqi_merge.sv
// merge of the lane results: nearest candidate, later edge wins a tie
module seqi_merge (
  input  logic                clk,
  input  logic                en,
  input  seqi_pkg::lane_res_t lane_res [seqi_pkg::LANES],
  output seqi_pkg::pick_t     pick
);

  localparam int IDX_W = seqi_pkg::IDX_W;

  seqi_pkg::pick_t best;

  always_comb begin
    best = '0;
    for (int n = 0; n < seqi_pkg::LANES; n++) begin
      if (lane_res[n].cand && (!best.tag.hit || lane_res[n].frac <= best.tag.frac)) begin
        best.tag.hit  = 1'b1;
        best.tag.frac = lane_res[n].frac;
        best.tag.idx  = IDX_W'(n);
        best.bx       = lane_res[n].bx;
        best.by       = lane_res[n].by;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pick <= best;
    end
  end

endmodule

FILE: sv/seqi_normal.sv
// unit outward normal: squares, pipelined square root and two pipelined dividers
module seqi_normal (
  input  logic            clk,
  input  logic            en,
  input  seqi_pkg::pick_t pick,
  output seqi_pkg::res_t  res
);

  localparam int CW      = seqi_pkg::CW;
  localparam int BW      = seqi_pkg::BW;
  localparam int LEN_W   = seqi_pkg::LEN_W;
  localparam int SQ_W    = seqi_pkg::SQ_W;
  localparam int REM_W   = seqi_pkg::REM_W;
  localparam int DR_W    = seqi_pkg::DR_W;
  localparam int QN_W    = seqi_pkg::QN_W;
  localparam int NORM_W  = seqi_pkg::NORM_W;
  localparam int Q14_SH  = seqi_pkg::Q14_SH;
  localparam int ONE_Q14 = seqi_pkg::ONE_Q14;

  logic signed [BW-1:0] abs_x, abs_y;

  seqi_pkg::tag_t tag_a, tag_b, tag_c;
  logic           ngx_a, ngy_a, ngx_b, ngy_b, ngx_c, ngy_c;
  logic [CW-1:0]  ax_a, ay_a, ax_b, ay_b, ax_c, ay_c;
  logic [2*CW-1:0] sqx_b, sqy_b;
  logic [SQ_W-1:0] sum_c;

  logic [REM_W-1:0]  sr_rem  [LEN_W];
  logic [LEN_W-1:0]  sr_root [LEN_W];
  logic [SQ_W-1:0]   sr_s    [LEN_W];
  seqi_pkg::tag_t    sr_tag  [LEN_W];
  logic              sr_ngx  [LEN_W];
  logic              sr_ngy  [LEN_W];
  logic [CW-1:0]     sr_ax   [LEN_W];
  logic [CW-1:0]     sr_ay   [LEN_W];

  logic [LEN_W-1:0]  len;
  logic [DR_W-1:0]   numx_d, numy_d;
  logic [LEN_W-1:0]  len_d;
  seqi_pkg::tag_t    tag_d;
  logic              ngx_d, ngy_d;

  logic [DR_W-1:0]   dv_rx  [QN_W];
  logic [DR_W-1:0]   dv_ry  [QN_W];
  logic [QN_W-1:0]   dv_qx  [QN_W];
  logic [QN_W-1:0]   dv_qy  [QN_W];
  logic [LEN_W-1:0]  dv_len [QN_W];
  seqi_pkg::tag_t    dv_tag [QN_W];
  logic              dv_ngx [QN_W];
  logic              dv_ngy [QN_W];

  logic [QN_W-1:0]   vx, vy;

  always_comb begin
    abs_x = pick.by[BW-1] ? -pick.by : pick.by;
    abs_y = pick.bx[BW-1] ? -pick.bx : pick.bx;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_a <= pick.tag;
      ngx_a <= pick.by[BW-1];
      ngy_a <= (pick.bx > 0);
      ax_a  <= abs_x[CW-1:0];
      ay_a  <= abs_y[CW-1:0];
      tag_b <= tag_a;
      ngx_b <= ngx_a;
      ngy_b <= ngy_a;
      ax_b  <= ax_a;
      ay_b  <= ay_a;
      sqx_b <= ax_a * ax_a;
      sqy_b <= ay_a * ay_a;
      tag_c <= tag_b;
      ngx_c <= ngx_b;
      ngy_c <= ngy_b;
      ax_c  <= ax_b;
      ay_c  <= ay_b;
      sum_c <= SQ_W'(sqx_b) + SQ_W'(sqy_b);
    end
  end

  // square root, one result bit per stage
  for (genvar i = 0; i < LEN_W; i++) begin : g_sqrt
    logic [REM_W-1:0] rin, rsh, trial;
    logic [LEN_W-1:0] rtin;
    logic [SQ_W-1:0]  sin;
    seqi_pkg::tag_t   tin;
    logic             gxin, gyin, ge;
    logic [CW-1:0]    axin, ayin;
    if (i == 0) begin : g_first
      assign rin  = '0;
      assign rtin = '0;
      assign sin  = sum_c;
      assign tin  = tag_c;
      assign gxin = ngx_c;
      assign gyin = ngy_c;
      assign axin = ax_c;
      assign ayin = ay_c;
    end else begin : g_next
      assign rin  = sr_rem[i-1];
      assign rtin = sr_root[i-1];
      assign sin  = sr_s[i-1];
      assign tin  = sr_tag[i-1];
      assign gxin = sr_ngx[i-1];
      assign gyin = sr_ngy[i-1];
      assign axin = sr_ax[i-1];
      assign ayin = sr_ay[i-1];
    end
    always_comb begin
      rsh   = {rin[REM_W-3:0], sin[SQ_W-1-2*i -: 2]};
      trial = REM_W'({rtin, 2'b01});
      ge    = rsh >= trial;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sr_rem[i]  <= ge ? rsh - trial : rsh;
        sr_root[i] <= {rtin[LEN_W-2:0], ge};
        sr_s[i]    <= sin;
        sr_tag[i]  <= tin;
        sr_ngx[i]  <= gxin;
        sr_ngy[i]  <= gyin;
        sr_ax[i]   <= axin;
        sr_ay[i]   <= ayin;
      end
    end
  end

  assign len = sr_root[LEN_W-1];

  // rounded numerators
  always_ff @(posedge clk) begin
    if (en) begin
      numx_d <= (DR_W'(sr_ax[LEN_W-1]) << Q14_SH) + DR_W'(len >> 1);
      numy_d <= (DR_W'(sr_ay[LEN_W-1]) << Q14_SH) + DR_W'(len >> 1);
      len_d  <= len;
      tag_d  <= sr_tag[LEN_W-1];
      ngx_d  <= sr_ngx[LEN_W-1];
      ngy_d  <= sr_ngy[LEN_W-1];
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar j = 0; j < QN_W; j++) begin : g_div
    logic [DR_W-1:0]  rxin, ryin, dsh;
    logic [QN_W-1:0]  qxin, qyin;
    logic [LEN_W-1:0] lin;
    seqi_pkg::tag_t   tin;
    logic             gxin, gyin, gex, gey;
    if (j == 0) begin : g_first
      assign rxin = numx_d;
      assign ryin = numy_d;
      assign qxin = '0;
      assign qyin = '0;
      assign lin  = len_d;
      assign tin  = tag_d;
      assign gxin = ngx_d;
      assign gyin = ngy_d;
    end else begin : g_next
      assign rxin = dv_rx[j-1];
      assign ryin = dv_ry[j-1];
      assign qxin = dv_qx[j-1];
      assign qyin = dv_qy[j-1];
      assign lin  = dv_len[j-1];
      assign tin  = dv_tag[j-1];
      assign gxin = dv_ngx[j-1];
      assign gyin = dv_ngy[j-1];
    end
    always_comb begin
      dsh = DR_W'(lin) << (QN_W - 1 - j);
      gex = rxin >= dsh;
      gey = ryin >= dsh;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_rx[j]  <= gex ? rxin - dsh : rxin;
        dv_ry[j]  <= gey ? ryin - dsh : ryin;
        dv_qx[j]  <= {qxin[QN_W-2:0], gex};
        dv_qy[j]  <= {qyin[QN_W-2:0], gey};
        dv_len[j] <= lin;
        dv_tag[j] <= tin;
        dv_ngx[j] <= gxin;
        dv_ngy[j] <= gyin;
      end
    end
  end

  always_comb begin
    if (dv_len[QN_W-1] == '0) begin
      vx = '0;
      vy = '0;
    end else begin
      vx = (dv_qx[QN_W-1] > QN_W'(ONE_Q14)) ? QN_W'(ONE_Q14) : dv_qx[QN_W-1];
      vy = (dv_qy[QN_W-1] > QN_W'(ONE_Q14)) ? QN_W'(ONE_Q14) : dv_qy[QN_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.tag <= dv_tag[QN_W-1];
      res.nx  <= dv_ngx[QN_W-1] ? -NORM_W'(vx) : NORM_W'(vx);
      res.ny  <= dv_ngy[QN_W-1] ? -NORM_W'(vy) : NORM_W'(vy);
    end
  end

endmodule

FILE: sv/segment_quad_edge_intersect.sv
// top level: segment against quadrilateral edges, nearest facing edge hit
//
// item channel takes one word per segment: start point, path vector and the
// four corners of a quadrilateral, signed Q15.8. result channel returns one
// word per item: hit flag, path fraction Q1.16, edge index and the unit
// outward normal Q1.14 (all zero when nothing is hit).
// the edge lanes, one per quadrilateral side, run in parallel; a merge stage picks
// the nearest hit, and a normal unit takes the square root and two divides.
// the edge lanes hold product stages and a one-bit-per-stage fraction divider,
// a merge register follows, and the normal unit holds 25 square root stages
// and 15 divider stages. throughput is one word per cycle while the skid
// register is empty; every stage is fully pipelined.
// reset clears the stage valid bits and the skid valid flag; data registers
// are not reset.
// when the receiver stalls, the pending result goes to a skid register and
// the whole pipeline holds on the next cycle until it is taken.
`include "segment_quad_edge_intersect_assert.svh"

module segment_quad_edge_intersect (
  input  logic       clk,
  input  logic       rst,
  seqi_in_if.sink    item,
  seqi_out_if.source result
);

  localparam int LANES    = seqi_pkg::LANES;
  localparam int PIPE_LAT = seqi_pkg::PIPE_LAT;

  logic                en;
  logic [PIPE_LAT-1:0] vld;
  logic                pv;
  logic                skid_valid;
  seqi_pkg::res_t      skid;
  seqi_pkg::res_t      pres;
  seqi_pkg::res_t      sel;

  seqi_pkg::coord_t    cx [LANES];
  seqi_pkg::coord_t    cy [LANES];
  seqi_pkg::lane_res_t lane_res [LANES];
  seqi_pkg::pick_t     pick;

  assign cx[0] = item.corner0_x;
  assign cy[0] = item.corner0_y;
  assign cx[1] = item.corner1_x;
  assign cy[1] = item.corner1_y;
  assign cx[2] = item.corner2_x;
  assign cy[2] = item.corner2_y;
  assign cx[3] = item.corner3_x;
  assign cy[3] = item.corner3_y;

  assign en         = !skid_valid;
  assign item.ready = en;
  assign pv         = vld[PIPE_LAT-1];

  for (genvar n = 0; n < LANES; n++) begin : g_lane
    seqi_lane u_lane (
      .clk     (clk),
      .en      (en),
      .start_x (item.start_x),
      .start_y (item.start_y),
      .path_x  (item.path_x),
      .path_y  (item.path_y),
      .ca_x    (cx[n]),
      .ca_y    (cy[n]),
      .cb_x    (cx[(n + 1) % LANES]),
      .cb_y    (cy[(n + 1) % LANES]),
      .res     (lane_res[n])
    );
  end

  seqi_merge u_merge (
    .clk      (clk),
    .en       (en),
    .lane_res (lane_res),
    .pick     (pick)
  );

  seqi_normal u_normal (
    .clk  (clk),
    .en   (en),
    .pick (pick),
    .res  (pres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_LAT-2:0], item.valid};
    end
  end

  // skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (en) begin
      skid_valid <= pv && !result.ready;
    end else if (result.ready) begin
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && pv && !result.ready) begin
      skid <= pres;
    end
  end

  assign sel                 = skid_valid ? skid : pres;
  assign result.valid        = skid_valid || pv;
  assign result.hit          = sel.tag.hit;
  assign result.hit_fraction = sel.tag.frac;
  assign result.edge_index   = sel.tag.idx;
  assign result.normal_x     = sel.nx;
  assign result.normal_y     = sel.ny;

  `SEQI_ASSERT(a_skid_from_stall, clk, rst, $rose(skid_valid) |-> $past(pv && !result.ready))
  `SEQI_ASSERT_NEXT(a_skid_holds, clk, rst, skid_valid && !result.ready, skid_valid)
  `SEQI_ASSERT(a_miss_is_zero, clk, rst, result.valid && !result.hit |-> result.hit_fraction == '0 && result.edge_index == '0 && result.normal_x == '0 && result.normal_y == '0)
  `SEQI_ASSERT(a_hit_in_range, clk, rst, result.valid && result.hit |-> result.hit_fraction <= seqi_pkg::FRAC_ONE && result.normal_x <= seqi_pkg::ONE_Q14 && result.normal_x >= -seqi_pkg::ONE_Q14 && result.normal_y <= seqi_pkg::ONE_Q14 && result.normal_y >= -seqi_pkg::ONE_Q14)

endmodule
